@@ hw/rtl/mlfs_pkg.sv @@
// Shared types, constants and helpers for the memory LCD frame line sender.
// No dependencies; the front end, the back end and the top level import this package.
`default_nettype none

package mlfs_pkg;

    // Default panel geometry.
    localparam int PANEL_WIDTH_DEF  = 400;
    localparam int PANEL_HEIGHT_DEF = 240;

    // Panel command bytes.
    localparam logic [7:0] CMD_WRITE  = 8'h80;
    localparam logic [7:0] CMD_CLEAR  = 8'h20;
    localparam logic [7:0] VCOM_BIT   = 8'h40;
    localparam logic [7:0] BYTE_WHITE = 8'hFF;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;

    // Queue depths.
    localparam int CMD_Q_DEPTH = 2;
    localparam int OUT_Q_DEPTH = 2;

    // Input command kinds, also used as the queued operation.
    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PIXEL   = 2'd1,
        MODE_REFRESH = 2'd2,
        MODE_PIX_REF = 2'd3
    } t_mode;

    // One classified command: mirroring already applied, range already checked.
    typedef struct packed {
        t_mode       op;
        logic [7:0]  row;
        logic [6:0]  col;      // byte index within the row
        logic [2:0]  bit_sel;  // pixel within the byte, 0 is the MSB
        logic        black;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR_HDR,
        S_CLR_TAIL,
        S_PX_RD,
        S_PX_WR,
        S_FILL,
        S_REF_HDR,
        S_REF_ADR,
        S_REF_DATA,
        S_REF_T0,
        S_REF_T1
    } t_bstate;

    // Status from the back end, watched at the top level.
    typedef struct packed {
        logic hdr;   // the byte offered now is a command header
        logic vcom;  // current VCOM phase
    } t_bk_stat;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    // Set or clear one pixel of a byte; pixel 0 is the MSB.
    function automatic logic [7:0] px_apply(input logic [7:0] b, input logic [2:0] sel,
                                            input logic black);
        logic [7:0] mask;
        mask = 8'h80 >> sel;
        return black ? (b & ~mask) : (b | mask);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mlfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mlfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/mlfs_fifo.sv @@
// Small synchronous FIFO with valid/ready on both sides.
// No dependencies.
`default_nettype none

module mlfs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_valid,
    output logic                  o_wr_ready,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_ready,
    output logic      [WIDTH-1:0] o_rd_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mlfs_front.sv @@
// Front end: accepts input items, drops out-of-range ones, applies mirroring
// and hands a classified command on. Depends on mlfs_pkg.
`default_nettype none

module mlfs_front
    import mlfs_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_mode      i_mode,
    input  wire logic [8:0] i_x_pos,
    input  wire logic [7:0] i_y_pos,
    input  wire logic       i_draw_black,
    input  wire logic       i_mirror,
    output logic            o_cmd_valid,
    input  wire logic       i_cmd_ready,
    output t_cmd            o_cmd
);

    // Wide enough for any mirrored column below PANEL_WIDTH.
    localparam int XMW = $clog2(PANEL_WIDTH) + 1;

    logic           r_vld;
    logic           n_vld;
    t_cmd           r_cmd;
    t_cmd           w_cmd;
    logic           w_accept;
    logic           w_keep;
    logic           w_x_ok;
    logic           w_y_ok;
    logic [XMW-1:0] w_x_m;
    logic [7:0]     w_y_m;

    assign o_ready  = !r_vld || i_cmd_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_x_ok = int'(i_x_pos) < PANEL_WIDTH;
        w_y_ok = int'(i_y_pos) < PANEL_HEIGHT;
        case (i_mode)
            MODE_CLEAR:   w_keep = 1'b1;
            MODE_REFRESH: w_keep = w_y_ok;
            default:      w_keep = w_y_ok && w_x_ok;
        endcase

        w_x_m = i_mirror ? XMW'(PANEL_WIDTH - 1 - int'(i_x_pos)) : XMW'(i_x_pos);
        w_y_m = i_mirror ? 8'(PANEL_HEIGHT - 1 - int'(i_y_pos)) : i_y_pos;

        w_cmd.op      = i_mode;
        w_cmd.row     = w_y_m;
        w_cmd.col     = 7'(w_x_m >> 3);
        w_cmd.bit_sel = w_x_m[2:0];
        w_cmd.black   = i_draw_black;

        if (w_accept) begin
            n_vld = w_keep;
        end else begin
            n_vld = r_vld && !i_cmd_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

endmodule

`default_nettype wire

@@ hw/rtl/mlfs_back.sv @@
// Back end: runs queued commands against the frame store and produces the
// panel byte stream. Depends on mlfs_pkg and mlfs_ram.
`default_nettype none

module mlfs_back
    import mlfs_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    output logic            o_cmd_ready,
    input  wire t_cmd       i_cmd,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last,
    output t_bk_stat        o_stat
);

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int IW          = $clog2(ROW_BYTES + 1);
    localparam int RIW         = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

    t_bstate                 r_state;
    t_bstate                 n_state;
    t_cmd                    r_cmd;
    logic [AW-1:0]           r_base;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           n_idx;
    logic                    r_dv;
    logic                    n_dv;
    logic                    r_vcom;
    logic                    n_vcom;
    logic [PANEL_HEIGHT-1:0] r_row_vld;
    logic                    w_vld_set;
    logic                    w_vld_clr;
    logic                    w_row_ok;
    logic                    w_drain;
    logic                    w_ram_we;
    logic [AW-1:0]           w_ram_waddr;
    logic [7:0]              w_ram_wdata;
    logic                    w_ram_re;
    logic [AW-1:0]           w_ram_raddr;
    logic [7:0]              w_ram_rdata;

    mlfs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // A row never written since reset or the last clear reads as white.
    assign w_row_ok = r_row_vld[r_cmd.row[RIW-1:0]];

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_dv        = r_dv;
        n_vcom      = r_vcom;
        o_cmd_ready = 1'b0;
        o_out_valid = 1'b0;
        o_out_byte  = BYTE_ZERO;
        o_out_last  = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_base + AW'(r_cmd.col);
        w_ram_wdata = BYTE_WHITE;
        w_ram_re    = 1'b0;
        w_ram_raddr = r_base + AW'(r_cmd.col);
        w_vld_set   = 1'b0;
        w_vld_clr   = 1'b0;
        w_drain     = !r_dv || i_out_ready;
        o_stat.hdr  = 1'b0;
        o_stat.vcom = r_vcom;

        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_idx = '0;
                    case (i_cmd.op)
                        MODE_CLEAR:   n_state = S_CLR_HDR;
                        MODE_REFRESH: n_state = S_REF_HDR;
                        default: begin
                            n_state = r_row_vld[i_cmd.row[RIW-1:0]] ? S_PX_RD : S_FILL;
                        end
                    endcase
                end
            end
            S_CLR_HDR: begin
                o_stat.hdr  = 1'b1;
                o_out_valid = 1'b1;
                o_out_byte  = CMD_CLEAR | (r_vcom ? BYTE_ZERO : VCOM_BIT);
                if (i_out_ready) begin
                    n_vcom    = !r_vcom;
                    w_vld_clr = 1'b1;
                    n_state   = S_CLR_TAIL;
                end
            end
            S_CLR_TAIL: begin
                o_out_valid = 1'b1;
                o_out_last  = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_PX_RD: begin
                w_ram_re = 1'b1;
                n_state  = S_PX_WR;
            end
            S_PX_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = px_apply(w_ram_rdata, r_cmd.bit_sel, r_cmd.black);
                n_state     = (r_cmd.op == MODE_PIX_REF) ? S_REF_HDR : S_IDLE;
            end
            S_FILL: begin
                // First write to a row since clear: paint it white around the pixel.
                w_ram_we    = 1'b1;
                w_ram_waddr = r_base + AW'(r_idx);
                if (r_idx == IW'(r_cmd.col)) begin
                    w_ram_wdata = px_apply(BYTE_WHITE, r_cmd.bit_sel, r_cmd.black);
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == IW'(ROW_BYTES - 1)) begin
                    w_vld_set = 1'b1;
                    n_idx     = '0;
                    n_state   = (r_cmd.op == MODE_PIX_REF) ? S_REF_HDR : S_IDLE;
                end
            end
            S_REF_HDR: begin
                o_stat.hdr  = 1'b1;
                o_out_valid = 1'b1;
                o_out_byte  = CMD_WRITE | (r_vcom ? BYTE_ZERO : VCOM_BIT);
                if (i_out_ready) begin
                    n_vcom  = !r_vcom;
                    n_state = S_REF_ADR;
                end
            end
            S_REF_ADR: begin
                o_out_valid = 1'b1;
                o_out_byte  = rev8(r_cmd.row + 8'd1);
                if (i_out_ready) begin
                    n_idx   = '0;
                    n_dv    = 1'b0;
                    n_state = S_REF_DATA;
                end
            end
            S_REF_DATA: begin
                // One read ahead: the RAM output register holds a byte until taken.
                o_out_valid = r_dv;
                o_out_byte  = w_row_ok ? w_ram_rdata : BYTE_WHITE;
                if (w_drain) begin
                    if (r_idx != IW'(ROW_BYTES)) begin
                        w_ram_re    = 1'b1;
                        w_ram_raddr = r_base + AW'(r_idx);
                        n_idx       = r_idx + 1'b1;
                        n_dv        = 1'b1;
                    end else begin
                        n_dv    = 1'b0;
                        n_state = S_REF_T0;
                    end
                end
            end
            S_REF_T0: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_REF_T1;
                end
            end
            S_REF_T1: begin
                o_out_valid = 1'b1;
                o_out_last  = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_dv      <= 1'b0;
            r_vcom    <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_dv    <= n_dv;
            r_vcom  <= n_vcom;
            if (w_vld_clr) begin
                r_row_vld <= '0;
            end else if (w_vld_set) begin
                r_row_vld[r_cmd.row[RIW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd  <= i_cmd;
            r_base <= AW'(int'(i_cmd.row) * ROW_BYTES);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/memory_lcd_frame_line_sender.sv @@
// Channel   Direction  Transfer holds
// s_axis    in         tuser: mode; tdata: x_pos, y_pos, draw_black
// m_axis    out        tdata: out_byte; tlast: last_byte
// cfg       in         wdata: mirror_screen
//
// Flow: a pixel write reads and rewrites one byte of the frame store when its row
// was written since the last clear, else the whole row is painted white first. A
// refresh sends its row bytes at one byte per cycle out of the frame store read port
// while the output is not stalled. Input transfers are taken each cycle while the
// command queue has room.
// Reset: synchronous, active low; the frame store needs no clearing pass, one
// valid bit per row makes unwritten rows read white.
// Stalls: the front end and the back end are decoupled by a two-entry command
// queue, and the output has a two-entry skid queue.
//
// Top level of the memory LCD frame line sender. Depends on mlfs_pkg,
// mlfs_front, mlfs_fifo and mlfs_back.
`default_nettype none

module memory_lcd_frame_line_sender
    import mlfs_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input command stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // [8:0] x_pos, [16:9] y_pos, [17] draw_black
    input  wire logic [1:0]  i_s_axis_tuser,  // [1:0] mode
    // Output byte stream to the panel.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,  // [7:0] out_byte
    output logic             o_m_axis_tlast,
    // Configuration: mirror_screen.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata
);

    logic       r_mirror;
    logic       w_front_valid;
    logic       w_front_ready;
    t_cmd       w_front_cmd;
    logic       w_q_valid;
    logic       w_q_ready;
    logic [CMD_W-1:0] w_q_data;
    logic       w_bk_valid;
    logic       w_bk_ready;
    logic [7:0] w_bk_byte;
    logic       w_bk_last;
    t_bk_stat   w_bk_stat;
    logic [8:0] w_out_data;

    // The user may change the mirror setting only while the block is idle (the block
    // does not enforce it), so the front end may apply it as the command is classified.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror <= 1'b1;
        end else if (i_cfg_we) begin
            r_mirror <= i_cfg_wdata;
        end
    end

    mlfs_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_mode       (t_mode'(i_s_axis_tuser)),
        .i_x_pos      (i_s_axis_tdata[8:0]),
        .i_y_pos      (i_s_axis_tdata[16:9]),
        .i_draw_black (i_s_axis_tdata[17]),
        .i_mirror     (r_mirror),
        .o_cmd_valid  (w_front_valid),
        .i_cmd_ready  (w_front_ready),
        .o_cmd        (w_front_cmd)
    );

    // Command queue between the front end and the back end.
    mlfs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_front_ready),
        .i_wr_data  (w_front_cmd),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_data  (w_q_data)
    );

    mlfs_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (t_cmd'(w_q_data)),
        .o_out_valid (w_bk_valid),
        .i_out_ready (w_bk_ready),
        .o_out_byte  (w_bk_byte),
        .o_out_last  (w_bk_last),
        .o_stat      (w_bk_stat)
    );

    // Output skid queue: the back end keeps working while the panel side stalls, until the queue is full.
    mlfs_fifo #(
        .WIDTH (9),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_bk_valid),
        .o_wr_ready (w_bk_ready),
        .i_wr_data  ({w_bk_last, w_bk_byte}),
        .o_rd_valid (o_m_axis_tvalid),
        .i_rd_ready (i_m_axis_tready),
        .o_rd_data  (w_out_data)
    );

    assign o_m_axis_tdata = w_out_data[7:0];
    assign o_m_axis_tlast = w_out_data[8];

    // Every header transfer flips VCOM on the following cycle.
    ap_vcom_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bk_stat.hdr && w_bk_valid && w_bk_ready) |=>
            (w_bk_stat.vcom != $past(w_bk_stat.vcom)))
        else $error("VCOM did not toggle after a header transfer");

    // VCOM never changes except right after a header transfer.
    ap_vcom_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bk_stat.vcom != $past(w_bk_stat.vcom)) |->
            $past(w_bk_stat.hdr && w_bk_valid && w_bk_ready))
        else $error("VCOM changed without a header transfer");

    // The header carries the new VCOM phase.
    ap_hdr_vcom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bk_stat.hdr && w_bk_valid) |-> (w_bk_byte[6] == !w_bk_stat.vcom))
        else $error("header VCOM bit does not match the toggled phase");

    // Every frame ends with a zero trailer byte.
    ap_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bk_valid && w_bk_last) |-> (w_bk_byte == BYTE_ZERO))
        else $error("last byte of a frame is not zero");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for memory_lcd_frame_line_sender: a directed table, then random
// clear, pixel and refresh commands under random flow control. Depends on mlfs_pkg and the RTL.

module tb;
    import mlfs_pkg::*;

    localparam int W = PANEL_WIDTH_DEF;
    localparam int H = PANEL_HEIGHT_DEF;
    localparam int ROW_BYTES = (W + 7) / 8;
    // Pixel writes give no output, so after the last byte the back end may still be
    // busy with up to four pending writes, each of which may paint a whole row white.
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS_PER_PHASE = 78;
    localparam int DIR_ROWS = 21;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } panel_byte_t;

    // How a row of the directed table is checked: by the shadow model, or against
    // a result typed into the table (nothing, a clear frame, or an all-white row).
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_SILENT,
        CHK_CLEAR,
        CHK_BLANK_ROW
    } chk_kind_t;

    typedef struct packed {
        t_mode      mode;
        logic [8:0] x;
        logic [7:0] y;
        logic       black;
        chk_kind_t  chk;
        logic [7:0] hdr;
        logic [7:0] adr;
    } dir_row_t;

    // Clock, reset and every block input start at known values.
    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;

    wire logic       o_s_axis_tready;
    wire logic       o_m_axis_tvalid;
    wire logic [7:0] o_m_axis_tdata;
    wire logic       o_m_axis_tlast;

    // Shadow of the panel state: one bit per pixel, the VCOM phase and the mirror setting.
    logic [7:0]  shadow [H][ROW_BYTES];
    logic        vcom_now;
    logic        mirror_now;

    panel_byte_t fresh_bytes[$];  // bytes caused by the command just accepted
    panel_byte_t bytes_due[$];    // bytes still expected on the output, oldest first

    dir_row_t    dir_rows [DIR_ROWS];
    int          fail_count = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;

    // Receiver flow control state.
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    int          seg_left = 0;
    int          seg_style = 0;

    always #2 i_clk = ~i_clk;

    memory_lcd_frame_line_sender DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    function automatic logic [7:0] bit_reverse(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    task automatic whiten_store();
        for (int r = 0; r < H; r++) begin
            for (int c = 0; c < ROW_BYTES; c++) begin
                shadow[r][c] = BYTE_WHITE;
            end
        end
    endtask

    // Write-line frame: header with VCOM, reversed 1-based row address, the row, two zeros.
    task automatic stream_row(input int y);
        int row;
        row = mirror_now ? H - 1 - y : y;
        vcom_now = ~vcom_now;
        fresh_bytes.push_back({CMD_WRITE | (vcom_now ? VCOM_BIT : BYTE_ZERO), 1'b0});
        fresh_bytes.push_back({bit_reverse(8'(row + 1)), 1'b0});
        for (int i = 0; i < ROW_BYTES; i++) begin
            fresh_bytes.push_back({shadow[row][i], 1'b0});
        end
        fresh_bytes.push_back({BYTE_ZERO, 1'b0});
        fresh_bytes.push_back({BYTE_ZERO, 1'b1});
    endtask

    // Applies one accepted command to the shadow and collects the bytes it causes.
    // acted is low when the coordinates are out of range and the block must ignore it.
    task automatic model_command(input t_mode mode, input logic [8:0] x, input logic [7:0] y,
                                 input logic black, output logic acted);
        int col;
        int row;
        fresh_bytes.delete();
        acted = 1'b0;
        if (mode == MODE_CLEAR) begin
            acted = 1'b1;
            vcom_now = ~vcom_now;
            fresh_bytes.push_back({CMD_CLEAR | (vcom_now ? VCOM_BIT : BYTE_ZERO), 1'b0});
            fresh_bytes.push_back({BYTE_ZERO, 1'b1});
            whiten_store();
        end else if (y < H && (mode == MODE_REFRESH || x < W)) begin
            acted = 1'b1;
            if (mode != MODE_REFRESH) begin
                col = mirror_now ? W - 1 - int'(x) : int'(x);
                row = mirror_now ? H - 1 - int'(y) : int'(y);
                if (black) begin
                    shadow[row][col / 8] = shadow[row][col / 8] & ~(8'h80 >> (col % 8));
                end else begin
                    shadow[row][col / 8] = shadow[row][col / 8] | (8'h80 >> (col % 8));
                end
            end
            if (mode != MODE_PIXEL) begin
                stream_row(int'(y));
            end
        end
    endtask

    task automatic expect_fresh();
        foreach (fresh_bytes[i]) begin
            bytes_due.push_back(fresh_bytes[i]);
        end
    endtask

    // Offers one command and returns in the time step of the edge that accepted it.
    // The sender runs in bursts; between bursts it often drops tvalid for a while.
    task automatic offer(input t_mode mode, input logic [8:0] x, input logic [7:0] y,
                         input logic black);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_tdata <= {6'd0, black, y, x};
        s_tuser <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // The mirror register is only written while the block is idle: the sender stops,
    // every expected byte is drained, and the back end gets time to finish silent writes.
    task automatic set_mirror(input logic value);
        s_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        mirror_now = value;
    endtask

    // Receiver: segments of random length that are always ready, half ready or mostly
    // stalled, plus one long hold-off that lets both queues of the block fill up.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(1, 48);
                seg_style <= $urandom_range(0, 2);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_style)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Every output transfer is compared with the oldest expected byte.
    always @(posedge i_clk) begin : check_output
        panel_byte_t want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (bytes_due.size() == 0) begin
                $error("out_byte: nothing expected, got %h (last %b)",
                       o_m_axis_tdata, o_m_axis_tlast);
                fail_count++;
            end else begin
                want = bytes_due.pop_front();
                if (want.data !== o_m_axis_tdata) begin
                    $error("out_byte: expected %h, got %h", want.data, o_m_axis_tdata);
                    fail_count++;
                end
                if (want.last !== o_m_axis_tlast) begin
                    $error("last_byte: expected %b, got %b", want.last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** memory_lcd_frame_line_sender: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        logic       acted;
        t_mode      mode;
        logic [8:0] x;
        logic [7:0] y;
        logic       black;
        int         pick;
        int         acted_count;

        whiten_store();
        vcom_now = 1'b0;
        mirror_now = 1'b1;

        // Directed table, run with mirroring on (the reset value). Headers carry VCOM,
        // which toggles on each clear and each refresh that is not ignored. Mirrored,
        // row 0 is panel row 239 (address 0x0F) and row 239 is panel row 0 (0x80).
        dir_rows = '{
            '{MODE_CLEAR,   9'd0,   8'd0,   1'b0, CHK_CLEAR,     8'h60, 8'h00},
            '{MODE_REFRESH, 9'd0,   8'd0,   1'b0, CHK_BLANK_ROW, 8'h80, 8'h0F},
            '{MODE_REFRESH, 9'd399, 8'd239, 1'b1, CHK_BLANK_ROW, 8'hC0, 8'h80},
            '{MODE_PIXEL,   9'd0,   8'd0,   1'b1, CHK_SILENT,    8'h00, 8'h00},
            '{MODE_PIXEL,   9'd399, 8'd239, 1'b1, CHK_SILENT,    8'h00, 8'h00},
            // Column or row out of range: ignored, no write, no VCOM toggle.
            '{MODE_PIXEL,   9'd400, 8'd0,   1'b1, CHK_SILENT,    8'h00, 8'h00},
            '{MODE_PIXEL,   9'd511, 8'd255, 1'b0, CHK_SILENT,    8'h00, 8'h00},
            '{MODE_PIXEL,   9'd0,   8'd240, 1'b1, CHK_SILENT,    8'h00, 8'h00},
            '{MODE_REFRESH, 9'd0,   8'd240, 1'b0, CHK_SILENT,    8'h00, 8'h00},
            '{MODE_REFRESH, 9'd511, 8'd255, 1'b1, CHK_SILENT,    8'h00, 8'h00},
            '{MODE_PIX_REF, 9'd400, 8'd0,   1'b1, CHK_SILENT,    8'h00, 8'h00},
            '{MODE_PIX_REF, 9'd0,   8'd255, 1'b1, CHK_SILENT,    8'h00, 8'h00},
            // A refresh ignores the column, even one out of range.
            '{MODE_REFRESH, 9'd511, 8'd0,   1'b1, CHK_MODEL,     8'h00, 8'h00},
            '{MODE_PIX_REF, 9'd7,   8'd0,   1'b1, CHK_MODEL,     8'h00, 8'h00},
            '{MODE_PIX_REF, 9'd8,   8'd239, 1'b0, CHK_MODEL,     8'h00, 8'h00},
            '{MODE_PIX_REF, 9'd399, 8'd239, 1'b0, CHK_MODEL,     8'h00, 8'h00},
            '{MODE_PIXEL,   9'd200, 8'd120, 1'b1, CHK_MODEL,     8'h00, 8'h00},
            // A clear ignores all other fields and leaves every row white.
            '{MODE_CLEAR,   9'd511, 8'd255, 1'b1, CHK_CLEAR,     8'h20, 8'h00},
            '{MODE_REFRESH, 9'd0,   8'd0,   1'b0, CHK_BLANK_ROW, 8'hC0, 8'h0F},
            '{MODE_PIXEL,   9'd123, 8'd45,  1'b0, CHK_MODEL,     8'h00, 8'h00},
            '{MODE_CLEAR,   9'd0,   8'd0,   1'b0, CHK_CLEAR,     8'h20, 8'h00}
        };

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        set_mirror(1'b1);

        foreach (dir_rows[i]) begin
            offer(dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y, dir_rows[i].black);
            model_command(dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y, dir_rows[i].black,
                          acted);
            case (dir_rows[i].chk)
                CHK_MODEL: expect_fresh();
                CHK_CLEAR: begin
                    bytes_due.push_back({dir_rows[i].hdr, 1'b0});
                    bytes_due.push_back({BYTE_ZERO, 1'b1});
                end
                CHK_BLANK_ROW: begin
                    bytes_due.push_back({dir_rows[i].hdr, 1'b0});
                    bytes_due.push_back({dir_rows[i].adr, 1'b0});
                    repeat (ROW_BYTES) bytes_due.push_back({BYTE_WHITE, 1'b0});
                    bytes_due.push_back({BYTE_ZERO, 1'b0});
                    bytes_due.push_back({BYTE_ZERO, 1'b1});
                end
                default: ;
            endcase
        end

        // Random phases alternate the mirror setting. Pixel writes cluster on the
        // first and last rows so that refreshes read back rows with many changes.
        for (int phase = 0; phase < 4; phase++) begin
            set_mirror(1'(phase % 2));
            acted_count = 0;
            while (acted_count < RANDOM_ITEMS_PER_PHASE) begin
                if (phase == 0 && acted_count == 20) begin
                    hold_req <= 1'b1;
                end
                pick = $urandom_range(0, 99);
                x = 9'($urandom_range(0, W - 1));
                black = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0: y = 8'($urandom_range(0, 3));
                    1: y = 8'($urandom_range(H - 4, H - 1));
                    default: y = 8'($urandom_range(0, H - 1));
                endcase
                if (pick < 6) begin
                    mode = MODE_CLEAR;
                    x = 9'($urandom_range(0, 511));
                    y = 8'($urandom_range(0, 255));
                end else if (pick < 46) begin
                    mode = MODE_PIXEL;
                end else if (pick < 64) begin
                    mode = MODE_PIX_REF;
                end else if (pick < 80) begin
                    mode = MODE_REFRESH;
                    x = 9'($urandom_range(0, 511));
                end else begin
                    // Noise: coordinates out of range on one axis, anything on the other.
                    mode = t_mode'($urandom_range(1, 3));
                    if ($urandom_range(0, 1) == 0) begin
                        x = 9'($urandom_range(W, 511));
                        y = 8'($urandom_range(0, 255));
                    end else begin
                        x = 9'($urandom_range(0, 511));
                        y = 8'($urandom_range(H, 255));
                    end
                end
                offer(mode, x, y, black);
                model_command(mode, x, y, black, acted);
                expect_fresh();
                if (acted) begin
                    acted_count++;
                end
            end
        end

        s_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** memory_lcd_frame_line_sender: PASSED **");
        end else begin
            $display("** memory_lcd_frame_line_sender: FAILED **");
        end
        $finish;
    end

endmodule
